FILE: hw/rtl/srpa_pkg.sv
// Package for the serial receive packet assembler.
// Holds field widths, default parameter values, mode, status and sequencer codes.
// No dependencies; srpa_if and the top level refer to it by scoped names.
`default_nettype none

package srpa_pkg;

	// Widths of the item fields as seen on the channels.
	localparam int MODE_W    = 3;
	localparam int DATA_W    = 8;
	localparam int SEL_W     = 2;
	localparam int OFFSET_W  = 6;
	localparam int STATUS_W  = 2;
	localparam int FOUND_W   = 2;
	localparam int LENGTH_W  = 7;
	localparam int TIMEOUT_W = 16;

	// Default sizes of the buffer pool.
	localparam int NUM_BUFFERS_DEF  = 4;
	localparam int BUFFER_BYTES_DEF = 64;

	// Idle timeout after reset, in ticks.
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd50;

	typedef enum logic [MODE_W-1:0] {
		MODE_BYTE    = 3'd0,
		MODE_TICK    = 3'd1,
		MODE_FIND    = 3'd2,
		MODE_READ    = 3'd3,
		MODE_RELEASE = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK   = 2'd0,
		STATUS_DROP = 2'd1,
		STATUS_NONE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_PICK = 2'd1,
		ST_EXEC = 2'd2,
		ST_DONE = 2'd3
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srpa_if.sv
// Channel interfaces of the serial receive packet assembler: input items,
// result items and the configuration write channel. Depends on srpa_pkg.
`default_nettype none

interface srpa_in_if;
	logic                          valid;
	logic                          ready;
	logic [srpa_pkg::MODE_W-1:0]   mode;
	logic [srpa_pkg::DATA_W-1:0]   data_byte;
	logic [srpa_pkg::SEL_W-1:0]    buffer_select;
	logic [srpa_pkg::OFFSET_W-1:0] byte_offset;

	modport source (output valid, mode, data_byte, buffer_select, byte_offset, input ready);
	modport sink (input valid, mode, data_byte, buffer_select, byte_offset, output ready);
endinterface

interface srpa_out_if;
	logic                          valid;
	logic                          ready;
	logic [srpa_pkg::STATUS_W-1:0] status;
	logic [srpa_pkg::FOUND_W-1:0]  found_buffer;
	logic [srpa_pkg::LENGTH_W-1:0] packet_length;
	logic [srpa_pkg::DATA_W-1:0]   read_byte;
	logic                          packet_closed;

	modport source (output valid, status, found_buffer, packet_length, read_byte,
		packet_closed, input ready);
	modport sink (input valid, status, found_buffer, packet_length, read_byte,
		packet_closed, output ready);
endinterface

interface srpa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [srpa_pkg::TIMEOUT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/srpa_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module srpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/srpa_search.sv
// Lowest-set-bit search over the per-buffer flag vector, shared by the
// open-buffer and closed-buffer lookups. No dependencies.
`default_nettype none

module srpa_search #(
	parameter int N     = 4,
	parameter int IDX_W = 2
) (
	input  wire logic [N-1:0]     flags,
	output logic                  hit,
	output logic      [IDX_W-1:0] idx
);

	// Scanning from the top down leaves the lowest set position in idx.
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (flags[i]) begin
				hit = 1'b1;
				idx = IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/serial_rx_packet_assembler_unit.sv
// Top level of the serial receive packet assembler: sequencer, buffer state,
// result register. Depends on srpa_pkg, srpa_if, srpa_ram and srpa_search.
//
// Usage. Items arrive on rx_in (valid/ready) and carry a mode: byte received,
// timer tick, find a closed packet, read a stored byte, or release all closed
// packets. Each item gives exactly one result item on rx_out (valid/ready).
// The idle timeout is written through cfg, which is always ready; it should
// only be written while no item is in flight.
//
// Timing. An accepted item walks a four step sequencer: accept, buffer search,
// execute (state update and packet memory access), and result load. A new
// item is only taken after the result of the previous one has been loaded
// into the output register. The four sequencer steps, built around one search
// unit and one packet memory access per item, set the pace at which items are
// taken.
//
// Stalls. The result sits in an output register; the sequencer only waits in
// its last step when the previous result has not been taken yet.
//
// Reset. arst_n clears all fill counts, closed flags, the current buffer, the
// idle counter and the result valid flag, and loads the timeout with 50 ticks.
// The packet memory is not cleared; a read of a byte that was never written
// returns whatever the memory holds.
`default_nettype none

module serial_rx_packet_assembler_unit #(
	parameter int NUM_BUFFERS  = srpa_pkg::NUM_BUFFERS_DEF,
	parameter int BUFFER_BYTES = srpa_pkg::BUFFER_BYTES_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	srpa_in_if.sink     rx_in,
	srpa_out_if.source  rx_out,
	srpa_cfg_if.sink    cfg
);

	localparam int BUF_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int OFF_W  = $clog2(BUFFER_BYTES);
	localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
	localparam int DEPTH  = NUM_BUFFERS * BUFFER_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUFFER_BYTES);

	// Sequencer state and the captured item.
	srpa_pkg::state_t                  state_q, state_d;
	logic [srpa_pkg::MODE_W-1:0]       mode_q;
	logic [srpa_pkg::DATA_W-1:0]       data_q;
	logic [srpa_pkg::SEL_W-1:0]        sel_q;
	logic [srpa_pkg::OFFSET_W-1:0]     off_q;

	// Buffer pool bookkeeping.
	logic                              cur_valid_q;
	logic [BUF_W-1:0]                  cur_q;
	logic [NUM_BUFFERS-1:0]            closed_q;
	logic [FILL_W-1:0]                 fill_q [NUM_BUFFERS];
	logic [srpa_pkg::TIMEOUT_W-1:0]    idle_q;
	logic [srpa_pkg::TIMEOUT_W-1:0]    timeout_q;

	// Results of the search step, used by the execute step.
	logic                              hit_q;
	logic [BUF_W-1:0]                  idx_q;
	srpa_pkg::status_t                 status_q;

	// Values prepared in the execute step.
	logic [srpa_pkg::FOUND_W-1:0]      found_q;
	logic [srpa_pkg::LENGTH_W-1:0]     length_q;
	logic                              pclosed_q;
	logic                              rd_ok_q;

	// Output register.
	logic                              out_valid_q;
	logic [srpa_pkg::STATUS_W-1:0]     out_status_q;
	logic [srpa_pkg::FOUND_W-1:0]      out_found_q;
	logic [srpa_pkg::LENGTH_W-1:0]     out_length_q;
	logic [srpa_pkg::DATA_W-1:0]       out_byte_q;
	logic                              out_closed_q;

	// Sequencer controls.
	logic in_take, pick_en, exec_en, load_en;

	// Search unit and shared reads.
	logic [NUM_BUFFERS-1:0]            srch_flags;
	logic                              srch_hit;
	logic [BUF_W-1:0]                  srch_idx;
	logic                              need_new;
	logic [BUF_W-1:0]                  fill_addr;
	logic [FILL_W-1:0]                 fill_sel;
	logic [FILL_W-1:0]                 fill_inc;
	logic [srpa_pkg::TIMEOUT_W-1:0]    idle_next;
	logic                              rd_in_range;

	// Packet memory port.
	logic                              mem_we, mem_re;
	logic [ADDR_W-1:0]                 mem_waddr, mem_raddr;
	logic [srpa_pkg::DATA_W-1:0]       mem_rdata;

	//----------------------------------------------------------------------
	// Sequencer: next state.
	//----------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			srpa_pkg::ST_IDLE: begin
				if (rx_in.valid) begin
					state_d = srpa_pkg::ST_PICK;
				end
			end
			srpa_pkg::ST_PICK: state_d = srpa_pkg::ST_EXEC;
			srpa_pkg::ST_EXEC: state_d = srpa_pkg::ST_DONE;
			srpa_pkg::ST_DONE: begin
				if (!out_valid_q || rx_out.ready) begin
					state_d = srpa_pkg::ST_IDLE;
				end
			end
			default: state_d = srpa_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: step controls.
	always_comb begin
		rx_in.ready = 1'b0;
		pick_en     = 1'b0;
		exec_en     = 1'b0;
		load_en     = 1'b0;
		case (state_q)
			srpa_pkg::ST_IDLE: rx_in.ready = 1'b1;
			srpa_pkg::ST_PICK: pick_en = 1'b1;
			srpa_pkg::ST_EXEC: exec_en = 1'b1;
			srpa_pkg::ST_DONE: load_en = !out_valid_q || rx_out.ready;
			default: rx_in.ready = 1'b0;
		endcase
	end

	assign in_take = rx_in.valid && rx_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The item is held for the whole sequence.
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q <= rx_in.mode;
			data_q <= rx_in.data_byte;
			sel_q  <= rx_in.buffer_select;
			off_q  <= rx_in.byte_offset;
		end
	end

	//----------------------------------------------------------------------
	// Configuration: the timeout register is always writable.
	//----------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= srpa_pkg::TIMEOUT_RESET;
		end else if (cfg.valid) begin
			timeout_q <= cfg.data;
		end
	end

	//----------------------------------------------------------------------
	// Shared search: lowest closed buffer for a find, lowest open buffer
	// otherwise.
	//----------------------------------------------------------------------
	assign srch_flags = (mode_q == srpa_pkg::MODE_FIND) ? closed_q : ~closed_q;

	srpa_search #(
		.N     (NUM_BUFFERS),
		.IDX_W (BUF_W)
	) u_search (
		.flags (srch_flags),
		.hit   (srch_hit),
		.idx   (srch_idx)
	);

	// A byte needs a new buffer when there is none or the current one closed.
	assign need_new = !cur_valid_q || closed_q[cur_q];

	// One fill count read per cycle: the found buffer for a find, else the
	// current buffer.
	assign fill_addr = (mode_q == srpa_pkg::MODE_FIND) ? idx_q : cur_q;
	assign fill_sel  = fill_q[fill_addr];
	assign fill_inc  = fill_sel + FILL_W'(1);

	// The idle counter saturates at its top value.
	assign idle_next = (idle_q != '1) ? idle_q + srpa_pkg::TIMEOUT_W'(1) : idle_q;

	assign rd_in_range = (32'(sel_q) < NUM_BUFFERS) && (32'(off_q) < BUFFER_BYTES);

	//----------------------------------------------------------------------
	// Buffer state updates in the search and execute steps.
	//----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
			closed_q    <= '0;
			idle_q      <= '0;
			hit_q       <= 1'b0;
			idx_q       <= '0;
			status_q    <= srpa_pkg::STATUS_OK;
			found_q     <= '0;
			length_q    <= '0;
			pclosed_q   <= 1'b0;
			rd_ok_q     <= 1'b0;
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (pick_en) begin
			hit_q    <= srch_hit;
			idx_q    <= srch_idx;
			status_q <= srpa_pkg::STATUS_OK;
			if (mode_q == srpa_pkg::MODE_BYTE && need_new) begin
				if (srch_hit) begin
					cur_valid_q <= 1'b1;
					cur_q       <= srch_idx;
				end else begin
					cur_valid_q <= 1'b0;
					status_q    <= srpa_pkg::STATUS_DROP;
				end
			end
			if (mode_q == srpa_pkg::MODE_FIND && !srch_hit) begin
				status_q <= srpa_pkg::STATUS_NONE;
			end
		end else if (exec_en) begin
			found_q   <= '0;
			length_q  <= '0;
			pclosed_q <= 1'b0;
			rd_ok_q   <= 1'b0;
			case (mode_q)
				srpa_pkg::MODE_BYTE: begin
					if (status_q == srpa_pkg::STATUS_OK) begin
						if (fill_sel < FILL_FULL) begin
							fill_q[cur_q] <= fill_inc;
							if (fill_inc >= FILL_FULL) begin
								closed_q[cur_q] <= 1'b1;
								pclosed_q       <= 1'b1;
							end
						end
						idle_q <= '0;
					end
				end
				srpa_pkg::MODE_TICK: begin
					idle_q <= idle_next;
					if (cur_valid_q && !closed_q[cur_q] && fill_sel != '0 &&
						idle_next >= timeout_q) begin
						closed_q[cur_q] <= 1'b1;
						pclosed_q       <= 1'b1;
					end
				end
				srpa_pkg::MODE_FIND: begin
					if (hit_q) begin
						found_q  <= srpa_pkg::FOUND_W'(idx_q);
						length_q <= srpa_pkg::LENGTH_W'(fill_sel);
					end
				end
				srpa_pkg::MODE_READ: begin
					rd_ok_q <= rd_in_range;
				end
				srpa_pkg::MODE_RELEASE: begin
					for (int i = 0; i < NUM_BUFFERS; i++) begin
						if (closed_q[i]) begin
							closed_q[i] <= 1'b0;
							fill_q[i]   <= '0;
						end
					end
				end
				default: rd_ok_q <= 1'b0;
			endcase
		end
	end

	//----------------------------------------------------------------------
	// Packet memory: bytes are written in the execute step of a received
	// byte, and read in the execute step of a read item.
	//----------------------------------------------------------------------
	assign mem_we = exec_en && (mode_q == srpa_pkg::MODE_BYTE) &&
		(status_q == srpa_pkg::STATUS_OK) && (fill_sel < FILL_FULL);
	assign mem_waddr = ADDR_W'(32'(cur_q) * BUFFER_BYTES + 32'(fill_sel[OFF_W-1:0]));
	assign mem_re    = exec_en && (mode_q == srpa_pkg::MODE_READ) && rd_in_range;
	assign mem_raddr = ADDR_W'(32'(sel_q) * BUFFER_BYTES + 32'(off_q));

	srpa_ram #(
		.WIDTH (srpa_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (data_q),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	//----------------------------------------------------------------------
	// Output register. The read data stays put after the execute step, so
	// it can be loaded however long the previous result stalls.
	//----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_en) begin
			out_valid_q <= 1'b1;
		end else if (rx_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			out_status_q <= status_q;
			out_found_q  <= found_q;
			out_length_q <= length_q;
			out_byte_q   <= rd_ok_q ? mem_rdata : '0;
			out_closed_q <= pclosed_q;
		end
	end

	assign rx_out.valid         = out_valid_q;
	assign rx_out.status        = out_status_q;
	assign rx_out.found_buffer  = out_found_q;
	assign rx_out.packet_length = out_length_q;
	assign rx_out.read_byte     = out_byte_q;
	assign rx_out.packet_closed = out_closed_q;

`ifndef SYNTHESIS
	// An accepted item always enters the search step next.
	a_take_to_pick: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == srpa_pkg::ST_PICK)
		else $error("accepted item did not start the search step");

	// A current buffer that is still open can never be full.
	a_open_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_valid_q && !closed_q[cur_q]) |-> fill_q[cur_q] < FILL_FULL)
		else $error("open current buffer holds a full fill count");

	// A new result only appears out of the result load step.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == srpa_pkg::ST_DONE))
		else $error("result shown outside the load step");
`endif

endmodule

`default_nettype wire
